@@ sv/hsv_pkg.sv @@
// shared types, widths and constants of the hsv to rgb converter
package hsv_pkg;

    localparam int IDX_W  = 10;
    localparam int HUE_W  = 9;
    localparam int CH_W   = 8;
    localparam int FRAC_W = 6;
    localparam int SP_W   = 14;   // saturation times fraction

    localparam int LED_COUNT_DEF = 64;

    localparam int HUE_LAST   = 359;
    localparam int FRAC_LAST  = 59;
    localparam int SECTOR_DEG = 60;
    localparam int FULL_SCALE = 255;

    // hue / 60 as (hue * 1093) >> 16, exact for hue up to 359
    localparam int HUE_RECIP_MUL   = 1093;
    localparam int HUE_RECIP_SHIFT = 16;
    localparam int HUE_PROD_W      = 20;

    // x / 60 as (x * 17477) >> 20, exact for x up to 255 * 59
    localparam int DIV60_MUL   = 17477;
    localparam int DIV60_SHIFT = 20;
    localparam int DIV60_W     = 29;

    typedef enum logic [2:0] {
        SEC_RED_UP   = 3'd0,
        SEC_RED_DN   = 3'd1,
        SEC_GREEN_UP = 3'd2,
        SEC_GREEN_DN = 3'd3,
        SEC_BLUE_UP  = 3'd4,
        SEC_BLUE_DN  = 3'd5
    } t_sector;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } t_pix;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              idx_ok;
        logic              grey;
        t_sector           sector;
        logic [FRAC_W-1:0] frac;
        logic [CH_W-1:0]   sat;
        logic [CH_W-1:0]   val;
    } t_split;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             idx_ok;
        logic             grey;
        t_sector          sector;
        logic [CH_W-1:0]  val;
        logic [CH_W-1:0]  p;
        logic [CH_W-1:0]  q_k;   // 255 - s*f/60
        logic [CH_W-1:0]  t_k;   // 255 - s*(59-f)/60
    } t_coef;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             idx_ok;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } t_rgb;

endpackage

@@ sv/hsv_if.sv @@
// pixel request and color result channel interfaces
interface hsv_pix_if;
    logic                          valid;
    logic                          ready;
    logic [hsv_pkg::IDX_W-1:0]     led_index;
    logic [hsv_pkg::HUE_W-1:0]     hue;
    logic [hsv_pkg::CH_W-1:0]      saturation;
    logic [hsv_pkg::CH_W-1:0]      brightness;

    modport source(output valid, led_index, hue, saturation, brightness, input ready);
    modport sink(input valid, led_index, hue, saturation, brightness, output ready);
endinterface

interface hsv_rgb_if;
    logic                          valid;
    logic                          ready;
    logic [hsv_pkg::IDX_W-1:0]     pixel_index;
    logic                          index_ok;
    logic [hsv_pkg::CH_W-1:0]      red;
    logic [hsv_pkg::CH_W-1:0]      green;
    logic [hsv_pkg::CH_W-1:0]      blue;

    modport source(output valid, pixel_index, index_ok, red, green, blue, input ready);
    modport sink(input valid, pixel_index, index_ok, red, green, blue, output ready);
endinterface

@@ sv/hsv_to_rgb_converter_top.sv @@
// top level of the hsv to rgb pixel converter
//
// Converts one pixel request (led index, hue, saturation, brightness) into an
// 8-bit red, green and blue word. Hue values of 360 and above are treated as
// 359; zero saturation gives grey at the brightness level. The led index is
// copied to the result together with index_ok, which is high when the index
// lies below LED_COUNT; the color is computed either way. The block is a
// five-stage pipeline with valid/ready handshakes on both sides: it takes one
// word per clock cycle while the output side is not stalled. A stall backs
// up stage by stage, so empty stages still fill while the last result waits
// in the output register. Stages: hue clamp and sector split, saturation
// products, divide by 60, brightness products, channel arrangement into the
// output register.
module hsv_to_rgb_converter_top #(
    parameter int LED_COUNT = hsv_pkg::LED_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsv_pix_if.sink   i_pix,
    hsv_rgb_if.source o_rgb
);

    hsv_pkg::t_pix   w_pix;
    hsv_pkg::t_split w_split;
    hsv_pkg::t_coef  w_coef;
    hsv_pkg::t_rgb   w_rgb;
    logic            w_split_valid;
    logic            w_split_ready;
    logic            w_coef_valid;
    logic            w_coef_ready;
    logic            w_in_ready;
    logic            w_out_valid;

    // pack the incoming word
    assign w_pix.idx = i_pix.led_index;
    assign w_pix.hue = i_pix.hue;
    assign w_pix.sat = i_pix.saturation;
    assign w_pix.val = i_pix.brightness;
    assign i_pix.ready = w_in_ready;

    // stage 1: clamp, sector, fraction, index check
    hsv_split #(
        .LED_COUNT(LED_COUNT)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (w_in_ready),
        .i_pix   (w_pix),
        .o_valid (w_split_valid),
        .i_ready (w_split_ready),
        .o_split (w_split)
    );

    // stages 2 and 3: products with saturation, divide by 60
    hsv_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_split_valid),
        .o_ready (w_split_ready),
        .i_split (w_split),
        .o_valid (w_coef_valid),
        .i_ready (w_coef_ready),
        .o_coef  (w_coef)
    );

    // stages 4 and 5: products with brightness, arrangement by sector
    hsv_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_coef_valid),
        .o_ready (w_coef_ready),
        .i_coef  (w_coef),
        .o_valid (w_out_valid),
        .i_ready (o_rgb.ready),
        .o_rgb   (w_rgb)
    );

    // unpack the result word
    assign o_rgb.valid       = w_out_valid;
    assign o_rgb.pixel_index = w_rgb.idx;
    assign o_rgb.index_ok    = w_rgb.idx_ok;
    assign o_rgb.red         = w_rgb.red;
    assign o_rgb.green       = w_rgb.green;
    assign o_rgb.blue        = w_rgb.blue;

endmodule

@@ sv/hsv_split.sv @@
// stage 1: hue clamp, sector and fraction split, index range check
module hsv_split #(
    parameter int LED_COUNT = hsv_pkg::LED_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hsv_pkg::t_pix   i_pix,
    output logic            o_valid,
    input  logic            i_ready,
    output hsv_pkg::t_split o_split
);

    logic                             w_en;
    logic [hsv_pkg::HUE_W-1:0]        w_hue;
    logic [hsv_pkg::HUE_PROD_W-1:0]   w_hprod;
    logic [2:0]                       w_sec;
    logic [hsv_pkg::HUE_W-1:0]        w_frac;
    hsv_pkg::t_split                  n_split;
    hsv_pkg::t_split                  r_split;
    logic                             r_valid;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        w_hue   = (i_pix.hue > hsv_pkg::HUE_W'(hsv_pkg::HUE_LAST))
                  ? hsv_pkg::HUE_W'(hsv_pkg::HUE_LAST) : i_pix.hue;
        w_hprod = hsv_pkg::HUE_PROD_W'(w_hue) * hsv_pkg::HUE_PROD_W'(hsv_pkg::HUE_RECIP_MUL);
        w_sec   = w_hprod[hsv_pkg::HUE_RECIP_SHIFT +: 3];
        w_frac  = w_hue - hsv_pkg::HUE_W'(w_sec) * hsv_pkg::HUE_W'(hsv_pkg::SECTOR_DEG);

        n_split.idx    = i_pix.idx;
        n_split.idx_ok = ({1'b0, i_pix.idx} < (hsv_pkg::IDX_W+1)'(LED_COUNT));
        n_split.grey   = (i_pix.sat == '0);
        n_split.sector = hsv_pkg::t_sector'(w_sec);
        n_split.frac   = w_frac[hsv_pkg::FRAC_W-1:0];
        n_split.sat    = i_pix.sat;
        n_split.val    = i_pix.val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_split <= n_split;
        end
    end

    assign o_valid = r_valid;
    assign o_split = r_split;

endmodule

@@ sv/hsv_prod.sv @@
// stages 2 and 3: saturation products, then divide by 60 through a reciprocal
module hsv_prod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hsv_pkg::t_split i_split,
    output logic            o_valid,
    input  logic            i_ready,
    output hsv_pkg::t_coef  o_coef
);

    typedef struct packed {
        logic [hsv_pkg::IDX_W-1:0] idx;
        logic                      idx_ok;
        logic                      grey;
        hsv_pkg::t_sector          sector;
        logic [hsv_pkg::CH_W-1:0]  val;
        logic [hsv_pkg::CH_W-1:0]  p;
        logic [hsv_pkg::SP_W-1:0]  sf;
        logic [hsv_pkg::SP_W-1:0]  st;
    } t_sprod;

    logic                            w_en2;
    logic                            w_en3;
    logic [2*hsv_pkg::CH_W-1:0]      w_pprod;
    logic [hsv_pkg::DIV60_W-1:0]     w_qdiv;
    logic [hsv_pkg::DIV60_W-1:0]     w_tdiv;
    t_sprod                          n_s2;
    t_sprod                          r_s2;
    hsv_pkg::t_coef                  n_s3;
    hsv_pkg::t_coef                  r_s3;
    logic                            r_v2;
    logic                            r_v3;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign o_ready = w_en2;

    // stage 2 products
    always_comb begin
        w_pprod = (2*hsv_pkg::CH_W)'(i_split.val)
                * (2*hsv_pkg::CH_W)'(hsv_pkg::CH_W'(hsv_pkg::FULL_SCALE) - i_split.sat);

        n_s2.idx    = i_split.idx;
        n_s2.idx_ok = i_split.idx_ok;
        n_s2.grey   = i_split.grey;
        n_s2.sector = i_split.sector;
        n_s2.val    = i_split.val;
        n_s2.p      = w_pprod[2*hsv_pkg::CH_W-1:hsv_pkg::CH_W];
        n_s2.sf     = hsv_pkg::SP_W'(i_split.sat) * hsv_pkg::SP_W'(i_split.frac);
        n_s2.st     = hsv_pkg::SP_W'(i_split.sat)
                    * hsv_pkg::SP_W'(hsv_pkg::FRAC_W'(hsv_pkg::FRAC_LAST) - i_split.frac);
    end

    // stage 3 divide by 60 and complement
    always_comb begin
        w_qdiv = hsv_pkg::DIV60_W'(r_s2.sf) * hsv_pkg::DIV60_W'(hsv_pkg::DIV60_MUL);
        w_tdiv = hsv_pkg::DIV60_W'(r_s2.st) * hsv_pkg::DIV60_W'(hsv_pkg::DIV60_MUL);

        n_s3.idx    = r_s2.idx;
        n_s3.idx_ok = r_s2.idx_ok;
        n_s3.grey   = r_s2.grey;
        n_s3.sector = r_s2.sector;
        n_s3.val    = r_s2.val;
        n_s3.p      = r_s2.p;
        n_s3.q_k    = hsv_pkg::CH_W'(hsv_pkg::FULL_SCALE)
                    - w_qdiv[hsv_pkg::DIV60_SHIFT +: hsv_pkg::CH_W];
        n_s3.t_k    = hsv_pkg::CH_W'(hsv_pkg::FULL_SCALE)
                    - w_tdiv[hsv_pkg::DIV60_SHIFT +: hsv_pkg::CH_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en2) begin
                r_v2 <= i_valid;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2 <= n_s2;
        end
        if (w_en3) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_coef  = r_s3;

endmodule

@@ sv/hsv_mix.sv @@
// stages 4 and 5: brightness products, then channel arrangement into the output register
module hsv_mix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hsv_pkg::t_coef i_coef,
    output logic           o_valid,
    input  logic           i_ready,
    output hsv_pkg::t_rgb  o_rgb
);

    typedef struct packed {
        logic [hsv_pkg::IDX_W-1:0] idx;
        logic                      idx_ok;
        logic                      grey;
        hsv_pkg::t_sector          sector;
        logic [hsv_pkg::CH_W-1:0]  val;
        logic [hsv_pkg::CH_W-1:0]  p;
        logic [hsv_pkg::CH_W-1:0]  q;
        logic [hsv_pkg::CH_W-1:0]  t;
    } t_pqt;

    logic                         w_en4;
    logic                         w_en5;
    logic [2*hsv_pkg::CH_W-1:0]   w_qprod;
    logic [2*hsv_pkg::CH_W-1:0]   w_tprod;
    t_pqt                         n_s4;
    t_pqt                         r_s4;
    hsv_pkg::t_rgb                n_out;
    hsv_pkg::t_rgb                r_out;
    logic                         r_v4;
    logic                         r_v5;

    assign w_en5   = !r_v5 || i_ready;
    assign w_en4   = !r_v4 || w_en5;
    assign o_ready = w_en4;

    always_comb begin
        w_qprod = (2*hsv_pkg::CH_W)'(i_coef.val) * (2*hsv_pkg::CH_W)'(i_coef.q_k);
        w_tprod = (2*hsv_pkg::CH_W)'(i_coef.val) * (2*hsv_pkg::CH_W)'(i_coef.t_k);

        n_s4.idx    = i_coef.idx;
        n_s4.idx_ok = i_coef.idx_ok;
        n_s4.grey   = i_coef.grey;
        n_s4.sector = i_coef.sector;
        n_s4.val    = i_coef.val;
        n_s4.p      = i_coef.p;
        n_s4.q      = w_qprod[2*hsv_pkg::CH_W-1:hsv_pkg::CH_W];
        n_s4.t      = w_tprod[2*hsv_pkg::CH_W-1:hsv_pkg::CH_W];
    end

    always_comb begin
        n_out.idx    = r_s4.idx;
        n_out.idx_ok = r_s4.idx_ok;
        case (r_s4.sector)
            hsv_pkg::SEC_RED_UP: begin
                n_out.red = r_s4.val; n_out.green = r_s4.t;   n_out.blue = r_s4.p;
            end
            hsv_pkg::SEC_RED_DN: begin
                n_out.red = r_s4.q;   n_out.green = r_s4.val; n_out.blue = r_s4.p;
            end
            hsv_pkg::SEC_GREEN_UP: begin
                n_out.red = r_s4.p;   n_out.green = r_s4.val; n_out.blue = r_s4.t;
            end
            hsv_pkg::SEC_GREEN_DN: begin
                n_out.red = r_s4.p;   n_out.green = r_s4.q;   n_out.blue = r_s4.val;
            end
            hsv_pkg::SEC_BLUE_UP: begin
                n_out.red = r_s4.t;   n_out.green = r_s4.p;   n_out.blue = r_s4.val;
            end
            default: begin
                n_out.red = r_s4.val; n_out.green = r_s4.p;   n_out.blue = r_s4.q;
            end
        endcase
        // no saturation: plain grey at the brightness level
        if (r_s4.grey) begin
            n_out.red   = r_s4.val;
            n_out.green = r_s4.val;
            n_out.blue  = r_s4.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en4) begin
                r_v4 <= i_valid;
            end
            if (w_en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_s4 <= n_s4;
        end
        if (w_en5) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v5;
    assign o_rgb   = r_out;

endmodule
